// ===== design/multiwidth_alu_with_flags_defines.svh =====
// Assertion helpers used by the RTL top level.
`ifndef MULTIWIDTH_ALU_WITH_FLAGS_DEFINES_SVH
`define MULTIWIDTH_ALU_WITH_FLAGS_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define MWA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication after a fixed number of cycles, disabled in reset.
`define MWA_ASSERT_DELAY(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// ===== design/mwa_pkg.sv =====
`timescale 1ns / 1ps

package mwa_pkg;

  localparam int DATA_W  = 64;
  localparam int HALF_W  = DATA_W / 2;
  localparam int DIV_LAT = DATA_W;            // one quotient bit per stage
  localparam int MUL_LAT = 4;
  localparam int MUL_DLY = DIV_LAT - MUL_LAT; // realigns multiply with divide

  typedef logic [DATA_W-1:0] word_t;

  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_MOD = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    WSEL_8  = 2'd0,
    WSEL_16 = 2'd1,
    WSEL_32 = 2'd2,
    WSEL_64 = 2'd3
  } wsel_t;

  // Per-request data riding alongside the divider.
  typedef struct packed {
    logic [2:0] kind;
    wsel_t      wsel;
    word_t      r_as;   // add or subtract result, truncated
    logic       of;
    logic       cf;
    logic       bzero;
  } side_t;

  typedef struct packed {
    word_t lo;
    logic  ovf;
  } mul_res_t;

  function automatic word_t width_mask(wsel_t w);
    word_t m;
    unique case (w)
      WSEL_8:  m = {{(DATA_W-8){1'b0}}, {8{1'b1}}};
      WSEL_16: m = {{(DATA_W-16){1'b0}}, {16{1'b1}}};
      WSEL_32: m = {{(DATA_W-32){1'b0}}, {32{1'b1}}};
      WSEL_64: m = {DATA_W{1'b1}};
    endcase
    return m;
  endfunction

  function automatic logic top_bit(word_t x, wsel_t w);
    logic t;
    unique case (w)
      WSEL_8:  t = x[7];
      WSEL_16: t = x[15];
      WSEL_32: t = x[31];
      WSEL_64: t = x[DATA_W-1];
    endcase
    return t;
  endfunction

  function automatic word_t sext(word_t x, wsel_t w);
    word_t s;
    unique case (w)
      WSEL_8:  s = {{(DATA_W-8){x[7]}}, x[7:0]};
      WSEL_16: s = {{(DATA_W-16){x[15]}}, x[15:0]};
      WSEL_32: s = {{(DATA_W-32){x[31]}}, x[31:0]};
      WSEL_64: s = x;
    endcase
    return s;
  endfunction

endpackage

// ===== design/mwa_mul.sv =====
`timescale 1ns / 1ps

// Signed multiply, four stages: partial products, sum, sign fix, fit check.
module mwa_mul (
  input  logic              clk,
  input  mwa_pkg::word_t    a,
  input  mwa_pkg::word_t    b,
  input  mwa_pkg::wsel_t    wsel,
  output mwa_pkg::mul_res_t res
);

  localparam int H = mwa_pkg::HALF_W;
  localparam int W = mwa_pkg::DATA_W;

  mwa_pkg::word_t sa_c, sb_c;
  mwa_pkg::word_t ll, lh, hl, hh;
  mwa_pkg::word_t s1_sa, s1_sb;
  mwa_pkg::wsel_t s1_w, s2_w;
  logic [H+1:0]   mid;
  mwa_pkg::word_t s2_lo, s2_hi, s2_sa, s2_sb;
  mwa_pkg::word_t s3_lo, s3_hi;
  logic           s3_lofit;

  assign sa_c = mwa_pkg::sext(a, wsel);
  assign sb_c = mwa_pkg::sext(b, wsel);

  always_ff @(posedge clk) begin
    ll    <= sa_c[H-1:0] * sb_c[H-1:0];
    lh    <= sa_c[H-1:0] * sb_c[W-1:H];
    hl    <= sa_c[W-1:H] * sb_c[H-1:0];
    hh    <= sa_c[W-1:H] * sb_c[W-1:H];
    s1_sa <= sa_c;
    s1_sb <= sb_c;
    s1_w  <= wsel;
  end

  assign mid = {2'b00, ll[W-1:H]} + {2'b00, lh[H-1:0]} + {2'b00, hl[H-1:0]};

  always_ff @(posedge clk) begin
    s2_lo <= {mid[H-1:0], ll[H-1:0]};
    s2_hi <= hh + {{H{1'b0}}, lh[W-1:H]} + {{H{1'b0}}, hl[W-1:H]}
             + {{(W-2){1'b0}}, mid[H+1:H]};
    s2_sa <= s1_sa;
    s2_sb <= s1_sb;
    s2_w  <= s1_w;
  end

  // unsigned high half to signed high half
  always_ff @(posedge clk) begin
    s3_hi    <= s2_hi - (s2_sa[W-1] ? s2_sb : '0) - (s2_sb[W-1] ? s2_sa : '0);
    s3_lo    <= s2_lo;
    s3_lofit <= (s2_lo == mwa_pkg::sext(s2_lo, s2_w));
  end

  always_ff @(posedge clk) begin
    res.lo  <= s3_lo;
    res.ovf <= !((s3_hi == {W{s3_lo[W-1]}}) && s3_lofit);
  end

endmodule

// ===== design/mwa_div.sv =====
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per stage.
module mwa_div (
  input  logic           clk,
  input  mwa_pkg::word_t a,
  input  mwa_pkg::word_t b,
  output mwa_pkg::word_t q,
  output mwa_pkg::word_t rem
);

  localparam int W = mwa_pkg::DATA_W;
  localparam int N = mwa_pkg::DIV_LAT;

  mwa_pkg::word_t rem_p [0:N-1];
  mwa_pkg::word_t aq_p  [0:N-1];  // dividend bits out, quotient bits in
  mwa_pkg::word_t dv_p  [0:N-2];

  for (genvar i = 0; i < N; i++) begin : g_stage
    mwa_pkg::word_t rin, ain, bin;
    logic [W:0]     t, diff;

    if (i == 0) begin : g_first
      assign rin = '0;
      assign ain = a;
      assign bin = b;
    end else begin : g_rest
      assign rin = rem_p[i-1];
      assign ain = aq_p[i-1];
      assign bin = dv_p[i-1];
    end

    assign t    = {rin, ain[W-1]};
    assign diff = t - {1'b0, bin};

    always_ff @(posedge clk) begin
      rem_p[i] <= diff[W] ? t[W-1:0] : diff[W-1:0];
      aq_p[i]  <= {ain[W-2:0], !diff[W]};
    end

    if (i < N - 1) begin : g_pass
      always_ff @(posedge clk) begin
        dv_p[i] <= bin;
      end
    end
  end

  assign q   = aq_p[N-1];
  assign rem = rem_p[N-1];

endmodule

// ===== design/multiwidth_alu_with_flags.sv =====
`timescale 1ns / 1ps
// Multi-width integer ALU with x86-style flags.
// Request channel: drive kind, width_sel, left_value and right_value with
// start high; the request is taken at any clock edge where start is high and
// busy is low. busy is tied low: a new request may enter every cycle.
// Result channel: done is high for exactly one cycle, and value_out plus the
// six flag outputs are valid during that cycle only. The receiver cannot
// stall, and no backpressure exists anywhere in the block.
// Every operation takes the same registered path: one input register, the
// 64-stage restoring divider (one quotient bit per stage), and one output
// register. Add/subtract and the four-stage multiplier run in parallel and
// are delayed to line up with the divider. Throughput is one request per
// cycle.
// Reset (rst, synchronous) clears all valid bits; requests in flight are
// dropped and done stays low until new requests come out.
// Byte multiply, divide and modulo report zero_only; a zero divisor reports
// div_error with a zero result and no flags; unused kinds give all zeros.
module multiwidth_alu_with_flags (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  kind,
  input  logic [1:0]  width_sel,
  input  logic [63:0] left_value,
  input  logic [63:0] right_value,
  output logic        busy,
  output logic        done,
  output logic [63:0] value_out,
  output logic        sign_flag,
  output logic        zero_flag,
  output logic        overflow_flag,
  output logic        carry_flag,
  output logic        zero_only,
  output logic        div_error
);

`include "multiwidth_alu_with_flags_defines.svh"

  localparam int N         = mwa_pkg::DIV_LAT;
  localparam int M         = mwa_pkg::MUL_DLY;
  localparam int TOTAL_LAT = mwa_pkg::DIV_LAT + 2;

  // input register
  logic           s0_vld;
  logic [2:0]     s0_kind;
  mwa_pkg::wsel_t s0_w;
  mwa_pkg::word_t s0_a, s0_b, in_mask;

  assign busy    = 1'b0;
  assign in_mask = mwa_pkg::width_mask(mwa_pkg::wsel_t'(width_sel));

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else begin
      s0_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_kind <= kind;
    s0_w    <= mwa_pkg::wsel_t'(width_sel);
    s0_a    <= left_value & in_mask;
    s0_b    <= right_value & in_mask;
  end

  // add / subtract, computed right after the input register
  mwa_pkg::word_t mask0, r_add, r_sub;
  mwa_pkg::side_t side_c;

  assign mask0 = mwa_pkg::width_mask(s0_w);
  assign r_add = (s0_a + s0_b) & mask0;
  assign r_sub = (s0_a - s0_b) & mask0;

  always_comb begin
    side_c.kind  = s0_kind;
    side_c.wsel  = s0_w;
    side_c.bzero = (s0_b == '0);
    if (s0_kind == mwa_pkg::KIND_SUB) begin
      side_c.r_as = r_sub;
      side_c.of   = mwa_pkg::top_bit((s0_a ^ s0_b) & (s0_a ^ r_sub), s0_w);
      side_c.cf   = (s0_a < s0_b);
    end else begin
      side_c.r_as = r_add;
      side_c.of   = mwa_pkg::top_bit((s0_a ^ r_add) & (s0_b ^ r_add), s0_w);
      side_c.cf   = (r_add < s0_a);
    end
  end

  // divider and multiplier
  mwa_pkg::word_t    quo, rem;
  mwa_pkg::mul_res_t mul_res;

  mwa_div u_div (
    .clk (clk),
    .a   (s0_a),
    .b   (s0_b),
    .q   (quo),
    .rem (rem)
  );

  mwa_mul u_mul (
    .clk  (clk),
    .a    (s0_a),
    .b    (s0_b),
    .wsel (s0_w),
    .res  (mul_res)
  );

  // alignment lines
  logic              vld_p  [0:N-1];
  mwa_pkg::side_t    side_p [0:N-1];
  mwa_pkg::mul_res_t mdl    [0:M-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) vld_p[i] <= 1'b0;
    end else begin
      vld_p[0] <= s0_vld;
      for (int i = 1; i < N; i++) vld_p[i] <= vld_p[i-1];
    end
  end

  always_ff @(posedge clk) begin
    side_p[0] <= side_c;
    for (int i = 1; i < N; i++) side_p[i] <= side_p[i-1];
    mdl[0] <= mul_res;
    for (int j = 1; j < M; j++) mdl[j] <= mdl[j-1];
  end

  // result select and flags
  mwa_pkg::side_t    sd;
  mwa_pkg::mul_res_t mr;
  mwa_pkg::word_t    r_next;
  logic              sf_next, zf_next, of_next, cf_next, zonly_next, derr_next, full;

  assign sd = side_p[N-1];
  assign mr = mdl[M-1];

  always_comb begin
    r_next     = '0;
    sf_next    = 1'b0;
    zf_next    = 1'b0;
    of_next    = 1'b0;
    cf_next    = 1'b0;
    zonly_next = 1'b0;
    derr_next  = 1'b0;
    full       = 1'b0;
    unique case (sd.kind)
      mwa_pkg::KIND_ADD, mwa_pkg::KIND_SUB: begin
        r_next  = sd.r_as;
        of_next = sd.of;
        cf_next = sd.cf;
        full    = 1'b1;
      end
      mwa_pkg::KIND_MUL: begin
        r_next = mr.lo & mwa_pkg::width_mask(sd.wsel);
        if (sd.wsel == mwa_pkg::WSEL_8) begin
          zf_next    = (r_next == '0);
          zonly_next = 1'b1;
        end else begin
          of_next = mr.ovf;
          cf_next = mr.ovf;
          full    = 1'b1;
        end
      end
      mwa_pkg::KIND_DIV, mwa_pkg::KIND_MOD: begin
        if (sd.bzero) begin
          derr_next = 1'b1;
        end else begin
          r_next     = (sd.kind == mwa_pkg::KIND_DIV) ? quo : rem;
          zf_next    = (r_next == '0);
          zonly_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (full) begin
      sf_next = mwa_pkg::top_bit(r_next, sd.wsel);
      zf_next = (r_next == '0);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_p[N-1];
    end
  end

  always_ff @(posedge clk) begin
    value_out     <= r_next;
    sign_flag     <= sf_next;
    zero_flag     <= zf_next;
    overflow_flag <= of_next;
    carry_flag    <= cf_next;
    zero_only     <= zonly_next;
    div_error     <= derr_next;
  end

  `MWA_ASSERT_DELAY(a_fixed_latency, start && !busy, (TOTAL_LAT), done, "request did not complete on time")
  `MWA_ASSERT_IMP(a_div_error_clean, done && div_error, value_out == '0 && !zero_only && !zero_flag, "divide error with data")
  `MWA_ASSERT_IMP(a_zero_only_flags, done && zero_only, !sign_flag && !overflow_flag && !carry_flag, "zero_only with other flags")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int LATENCY   = 66;
  localparam int MAX_CYC   = 400000;
  localparam int N_RANDOM  = 1250;

  typedef struct {
    logic [63:0] value;
    logic        sf;
    logic        zf;
    logic        of;
    logic        cf;
    logic        zonly;
    logic        derr;
  } alu_out_t;

  typedef struct {
    logic [2:0]     kind;
    mwa_pkg::wsel_t wsel;
    logic [63:0]    a;
    logic [63:0]    b;
    logic           typed;    // expected result given in the row
    logic [63:0]    value;
    logic           zf;
    logic           zonly;
    logic           derr;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [2:0]  kind = '0;
  logic [1:0]  width_sel = '0;
  logic [63:0] left_value = '0;
  logic [63:0] right_value = '0;
  logic        busy, done;
  logic [63:0] value_out;
  logic        sign_flag, zero_flag, overflow_flag, carry_flag, zero_only, div_error;

  alu_out_t    pending_q[$];
  int          n_fail = 0;
  int          cycle = 0;

  always #6 clk = ~clk;

  multiwidth_alu_with_flags i_dut (
    .clk(clk), .rst(rst), .start(start), .kind(kind), .width_sel(width_sel),
    .left_value(left_value), .right_value(right_value), .busy(busy), .done(done),
    .value_out(value_out), .sign_flag(sign_flag), .zero_flag(zero_flag),
    .overflow_flag(overflow_flag), .carry_flag(carry_flag), .zero_only(zero_only),
    .div_error(div_error)
  );

  // Timeout guard.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= MAX_CYC) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Predicted ALU result: width-truncated operands, x86 flag rules.
  function automatic alu_out_t alu_predict(logic [2:0] k, mwa_pkg::wsel_t ws,
                                           logic [63:0] a_in, logic [63:0] b_in);
    alu_out_t    o;
    int          w;
    logic [63:0] msk, top, a, b, r;
    logic signed [127:0] prod, lim;
    logic        full;
    w    = 8 << ws;
    msk  = (w == 64) ? '1 : ((64'd1 << w) - 1);
    top  = 64'd1 << (w - 1);
    a    = a_in & msk;
    b    = b_in & msk;
    r    = '0;
    full = 1'b0;
    o    = '{default: 1'b0, value: '0};
    case (k)
      mwa_pkg::KIND_ADD: begin
        r = (a + b) & msk;
        o.of = |((a ^ r) & (b ^ r) & top);
        o.cf = r < a;
        full = 1'b1;
      end
      mwa_pkg::KIND_SUB: begin
        r = (a - b) & msk;
        o.of = |((a ^ b) & (a ^ r) & top);
        o.cf = a < b;
        full = 1'b1;
      end
      mwa_pkg::KIND_MUL: begin
        r = (a * b) & msk;
        if (ws == mwa_pkg::WSEL_8) begin
          o.zf = r == 0;
          o.zonly = 1'b1;
        end else begin
          prod = $signed({{64{a[w-1]}}, mwa_pkg::sext(a, ws)})
                 * $signed({{64{b[w-1]}}, mwa_pkg::sext(b, ws)});
          lim  = 128'sd1 <<< (w - 1);
          o.of = (prod >= lim) || (prod < -lim);
          o.cf = o.of;
          full = 1'b1;
        end
      end
      mwa_pkg::KIND_DIV, mwa_pkg::KIND_MOD: begin
        if (b == 0) begin
          o.derr = 1'b1;
        end else begin
          r = (k == mwa_pkg::KIND_DIV) ? a / b : a % b;
          o.zf = r == 0;
          o.zonly = 1'b1;
        end
      end
      default: ;
    endcase
    if (full) begin
      o.sf = |(r & top);
      o.zf = r == 0;
    end
    o.value = r;
    return o;
  endfunction

  // Result checker: every done cycle must match the oldest pending request.
  always @(posedge clk) begin
    alu_out_t e;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result value_out=%h", value_out);
        n_fail++;
      end else begin
        e = pending_q.pop_front();
        if (value_out !== e.value) begin
          $error("value_out exp %h got %h", e.value, value_out); n_fail++;
        end
        if (sign_flag !== e.sf) begin
          $error("sign_flag exp %b got %b", e.sf, sign_flag); n_fail++;
        end
        if (zero_flag !== e.zf) begin
          $error("zero_flag exp %b got %b", e.zf, zero_flag); n_fail++;
        end
        if (overflow_flag !== e.of) begin
          $error("overflow_flag exp %b got %b", e.of, overflow_flag); n_fail++;
        end
        if (carry_flag !== e.cf) begin
          $error("carry_flag exp %b got %b", e.cf, carry_flag); n_fail++;
        end
        if (zero_only !== e.zonly) begin
          $error("zero_only exp %b got %b", e.zonly, zero_only); n_fail++;
        end
        if (div_error !== e.derr) begin
          $error("div_error exp %b got %b", e.derr, div_error); n_fail++;
        end
      end
    end
  end

  // Drive one request; hold start until busy is low at an edge.
  task automatic send_request(logic [2:0] k, mwa_pkg::wsel_t ws, logic [63:0] a,
                              logic [63:0] b, alu_out_t exp_out);
    start       <= 1'b1;
    kind        <= k;
    width_sel   <= ws;
    left_value  <= a;
    right_value <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(exp_out);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Operand biased toward boundary values of the chosen width.
  function automatic logic [63:0] pick_operand(mwa_pkg::wsel_t ws);
    logic [63:0] v;
    int          w;
    w = 8 << ws;
    v = rand64();
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = 64'd1;
      2: v = '1;
      3: v = 64'd1 << (w - 1);
      4: v = (64'd1 << (w - 1)) - 1;
      5: v = v & 64'hff;
      default: ;
    endcase
    return v;
  endfunction

  stim_row_t table_rows[] = '{
    // kind      wsel    a                     b                     typed value zf zo de
    '{mwa_pkg::KIND_ADD, mwa_pkg::WSEL_8,  64'hff, 64'h01,
      1'b0, 64'h0, 1'b0, 1'b0, 1'b0},
    '{mwa_pkg::KIND_ADD, mwa_pkg::WSEL_64, '1, '1,
      1'b0, 64'h0, 1'b0, 1'b0, 1'b0},
    '{mwa_pkg::KIND_ADD, mwa_pkg::WSEL_16, 64'h7fff, 64'h1,
      1'b0, 64'h0, 1'b0, 1'b0, 1'b0},
    '{mwa_pkg::KIND_ADD, mwa_pkg::WSEL_32, 64'hffff_ffff_8000_0000, 64'h8000_0000,
      1'b0, 64'h0, 1'b0, 1'b0, 1'b0},
    '{mwa_pkg::KIND_SUB, mwa_pkg::WSEL_8,  64'h00, 64'h01,
      1'b0, 64'h0, 1'b0, 1'b0, 1'b0},
    '{mwa_pkg::KIND_SUB, mwa_pkg::WSEL_64, 64'h8000_0000_0000_0000, 64'h1,
      1'b0, 64'h0, 1'b0, 1'b0, 1'b0},
    '{mwa_pkg::KIND_SUB, mwa_pkg::WSEL_16, 64'h1234, 64'h1234,
      1'b0, 64'h0, 1'b0, 1'b0, 1'b0},
    '{mwa_pkg::KIND_MUL, mwa_pkg::WSEL_8,  64'h10, 64'h10,
      1'b1, 64'h0, 1'b1, 1'b1, 1'b0},
    '{mwa_pkg::KIND_MUL, mwa_pkg::WSEL_8,  64'hff, 64'hff,
      1'b1, 64'h1, 1'b0, 1'b1, 1'b0},
    '{mwa_pkg::KIND_MUL, mwa_pkg::WSEL_16, 64'h8000, 64'hffff,
      1'b0, 64'h0, 1'b0, 1'b0, 1'b0},
    '{mwa_pkg::KIND_MUL, mwa_pkg::WSEL_32, 64'h7fff_ffff, 64'h2,
      1'b0, 64'h0, 1'b0, 1'b0, 1'b0},
    '{mwa_pkg::KIND_MUL, mwa_pkg::WSEL_64, 64'h8000_0000_0000_0000, '1,
      1'b0, 64'h0, 1'b0, 1'b0, 1'b0},
    '{mwa_pkg::KIND_MUL, mwa_pkg::WSEL_64, '1, '1,
      1'b0, 64'h0, 1'b0, 1'b0, 1'b0},
    '{mwa_pkg::KIND_DIV, mwa_pkg::WSEL_64, '1, 64'h1,
      1'b1, '1, 1'b0, 1'b1, 1'b0},
    '{mwa_pkg::KIND_DIV, mwa_pkg::WSEL_8,  64'h5, 64'h100,
      1'b1, 64'h0, 1'b0, 1'b0, 1'b1},
    '{mwa_pkg::KIND_DIV, mwa_pkg::WSEL_32, 64'h3, 64'h7,
      1'b1, 64'h0, 1'b1, 1'b1, 1'b0},
    '{mwa_pkg::KIND_MOD, mwa_pkg::WSEL_16, 64'h64, 64'h7,
      1'b1, 64'h2, 1'b0, 1'b1, 1'b0},
    '{mwa_pkg::KIND_MOD, mwa_pkg::WSEL_64, 64'h0, 64'h0,
      1'b1, 64'h0, 1'b0, 1'b0, 1'b1},
    '{mwa_pkg::KIND_MOD, mwa_pkg::WSEL_32, 64'h12_0000_000f, 64'h5,
      1'b1, 64'h0, 1'b1, 1'b1, 1'b0},
    '{3'd5, mwa_pkg::WSEL_64, '1, '1,
      1'b1, 64'h0, 1'b0, 1'b0, 1'b0},
    '{3'd6, mwa_pkg::WSEL_8,  64'h1, 64'h1,
      1'b1, 64'h0, 1'b0, 1'b0, 1'b0},
    '{3'd7, mwa_pkg::WSEL_16, 64'h0, 64'h0,
      1'b1, 64'h0, 1'b0, 1'b0, 1'b0}
  };

  initial begin
    alu_out_t       e;
    logic [2:0]     k;
    mwa_pkg::wsel_t ws;
    logic [63:0]    a_v, b_v;
    logic           no_idle;
    int             wait_cyc;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests, back to back.
    foreach (table_rows[i]) begin
      e = alu_predict(table_rows[i].kind, table_rows[i].wsel, table_rows[i].a,
                      table_rows[i].b);
      if (table_rows[i].typed) begin
        e = '{value: table_rows[i].value, sf: 1'b0, zf: table_rows[i].zf, of: 1'b0,
              cf: 1'b0, zonly: table_rows[i].zonly, derr: table_rows[i].derr};
      end
      send_request(table_rows[i].kind, table_rows[i].wsel, table_rows[i].a,
                   table_rows[i].b, e);
    end
    start <= 1'b0;

    // Drain fully before the random part.
    while (pending_q.size() != 0) @(posedge clk);

    for (int n = 0; n < N_RANDOM; n++) begin
      no_idle = (n >= 400 && n < 650);
      if (!no_idle && $urandom_range(0, 99) < 28) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      if (n == 900) begin
        // Let the pipeline empty completely mid-run.
        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
      end
      k   = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, 4));
      ws  = mwa_pkg::wsel_t'($urandom_range(0, 3));
      a_v = pick_operand(ws);
      b_v = pick_operand(ws);
      send_request(k, ws, a_v, b_v, alu_predict(k, ws, a_v, b_v));
    end
    start <= 1'b0;

    wait_cyc = 0;
    while (pending_q.size() != 0 && wait_cyc < 10 * LATENCY) begin
      @(posedge clk);
      wait_cyc++;
    end
    repeat (LATENCY + 4) @(posedge clk);

    if (n_fail == 0 && pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
